[hw/rtl/iihm_pkg.sv]
// shared constants, the word type and the mixing function for the integer hash mixer
package iihm_pkg;

	localparam int unsigned MixRounds = 16;

	localparam logic [31:0] SeedConst = 32'h9E37_79B9;
	localparam logic [31:0] MulA      = 32'h7FEB_352D;
	localparam logic [31:0] MulB      = 32'h846C_A68B;

	localparam int unsigned ShiftA = 16;
	localparam int unsigned ShiftB = 15;
	localparam int unsigned ShiftFinal = 16;

	// word travelling down the pipe: value plus the mode it was hashed under
	typedef struct packed {
		logic        full;
		logic [31:0] x;
	} word_t;

	// xorshift followed by a wrapping multiply, bypassed in light mode
	function automatic logic [31:0] shift_mul(input logic [31:0] x, input logic full,
			input int unsigned sh, input logic [31:0] k);
		logic [31:0] t;
		t = x ^ (x >> sh);
		shift_mul = full ? 32'(t * k) : x;
	endfunction

endpackage

[hw/rtl/iihm_round.sv]
// one mixing round: two registered xorshift-multiply stages with stall handling
module iihm_round (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           up_valid,
	input  iihm_pkg::word_t up_word,
	output logic           up_stall,
	output logic           dn_valid,
	output iihm_pkg::word_t dn_word,
	input  logic           dn_stall
);

	logic            valid_s1, valid_s2;
	iihm_pkg::word_t word_s1, word_s2;
	logic            adv_s1, adv_s2;

	// a stage moves when it is empty or its successor moves
	assign adv_s2   = !valid_s2 || !dn_stall;
	assign adv_s1   = !valid_s1 || adv_s2;
	assign up_stall = !adv_s1;

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (adv_s1) valid_s1 <= up_valid;
			if (adv_s2) valid_s2 <= valid_s1;
		end
	end

	// first half: xorshift 16, multiply
	always_ff @(posedge clk) begin
		if (adv_s1 && up_valid) begin
			word_s1.full <= up_word.full;
			word_s1.x    <= iihm_pkg::shift_mul(up_word.x, up_word.full,
				iihm_pkg::ShiftA, iihm_pkg::MulA);
		end
	end

	// second half: xorshift 15, multiply
	always_ff @(posedge clk) begin
		if (adv_s2 && valid_s1) begin
			word_s2.full <= word_s1.full;
			word_s2.x    <= iihm_pkg::shift_mul(word_s1.x, word_s1.full,
				iihm_pkg::ShiftB, iihm_pkg::MulB);
		end
	end

	assign dn_valid = valid_s2;
	assign dn_word  = word_s2;

endmodule

[hw/rtl/iterated_integer_hash_mixer.sv]
// top level of the iterated integer hash mixer: seed stage, round chain, final shift
//
//  channel | valid     | stall     | payload
//  --------+-----------+-----------+----------------------------
//  in      | in_valid  | in_stall  | data_word, element_index
//  out     | out_valid | out_stall | hashed_word
//  cfg     | cfg_wr_en | -         | cfg_wr_data (full_mix_mode)
//
// one word enters per cycle while in_stall is low; the path holds the seed register,
// one register after every multiply of the round chain and the output register.
// every stage holds its own valid bit and fills a bubble even while the output stalls.
// reset clears all valid bits and sets full mixing mode.
// the mode is sampled per word at the seed stage and travels with it.
module iterated_integer_hash_mixer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic        cfg_wr_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [31:0] data_word,
	input  logic [31:0] element_index,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] hashed_word
);

	localparam int unsigned Rounds = iihm_pkg::MixRounds;

	logic            mode_q;
	logic            valid_s1, valid_s2;
	iihm_pkg::word_t word_s1;
	logic [31:0]     hash_s2;
	logic            adv_s1, adv_s2;

	logic            chain_valid [0:Rounds];
	iihm_pkg::word_t chain_word  [0:Rounds];
	logic            chain_stall [0:Rounds];

	// mode register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) mode_q <= 1'b1;
		else if (cfg_wr_en) mode_q <= cfg_wr_data;
	end

	// stage advance
	assign adv_s2   = !valid_s2 || !out_stall;
	assign adv_s1   = !valid_s1 || !chain_stall[0];
	assign in_stall = !adv_s1;

	// valid bits of seed and final stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (adv_s1) valid_s1 <= in_valid;
			if (adv_s2) valid_s2 <= chain_valid[Rounds];
		end
	end

	// seed stage: xor with golden-ratio constant plus index
	always_ff @(posedge clk) begin
		if (adv_s1 && in_valid) begin
			word_s1.full <= mode_q;
			word_s1.x    <= data_word ^ 32'(iihm_pkg::SeedConst + element_index);
		end
	end

	assign chain_valid[0] = valid_s1;
	assign chain_word[0]  = word_s1;

	// round chain
	for (genvar r = 0; r < Rounds; r++) begin : g_round
		iihm_round u_round (
			.clk      (clk),
			.arst_n   (arst_n),
			.up_valid (chain_valid[r]),
			.up_word  (chain_word[r]),
			.up_stall (chain_stall[r]),
			.dn_valid (chain_valid[r+1]),
			.dn_word  (chain_word[r+1]),
			.dn_stall (chain_stall[r+1])
		);
	end

	assign chain_stall[Rounds] = !adv_s2;

	// final xorshift 16 in full mode, output register
	always_ff @(posedge clk) begin
		if (adv_s2 && chain_valid[Rounds]) begin
			hash_s2 <= chain_word[Rounds].full
				? (chain_word[Rounds].x ^ (chain_word[Rounds].x >> iihm_pkg::ShiftFinal))
				: chain_word[Rounds].x;
		end
	end

	assign out_valid   = valid_s2;
	assign hashed_word = hash_s2;

endmodule
